// File: hdl/assert_macros.svh
// Assertion macros shared by the binning index RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// File: hdl/biq_pkg.sv
// Types, constants and helpers for the binning index region query block.
package biq_pkg;

	localparam int DEF_NUM_CONTIGS = 2;
	localparam int DEF_MAX_DEPTH   = 5;

	localparam int POS_W      = 31;
	localparam int BIN_W      = 16;
	localparam int VOFF_W     = 64;
	localparam int BLK_W      = 16;
	localparam int COMP_W     = VOFF_W - BLK_W;
	localparam int SHIFT_W    = 5;
	localparam int DEPTH_W    = 3;
	localparam int LVL_W      = 3;
	localparam int LEVEL_BITS = 3;

	localparam logic [SHIFT_W-1:0] FINE_SHIFT_RST  = 5'd14;
	localparam logic [DEPTH_W-1:0] INDEX_DEPTH_RST = 3'd5;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_ORDER  = 2'd1,
		STAT_NO_BIN = 2'd2,
		STAT_RANGE  = 2'd3
	} status_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic {
		CFG_FINE_SHIFT  = 1'b0,
		CFG_INDEX_DEPTH = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_LEVEL,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              present;
		logic [VOFF_W-1:0] voff;
	} tbl_entry_t;

	// Bins in one contig's table: 1 + 8 + 64 + ... over all levels.
	function automatic int bins_per_contig(input int max_depth);
		int n;
		n = 0;
		for (int l = 0; l <= max_depth; l++) begin
			n += 1 << (LEVEL_BITS * l);
		end
		return n;
	endfunction

endpackage

// File: hdl/biq_table.sv
// Bin table memory: presence bit and virtual offset per bin, swept clear after reset.
module biq_table
	import biq_pkg::*;
#(
	parameter int NUM_CONTIGS = DEF_NUM_CONTIGS,
	parameter int MAX_DEPTH   = DEF_MAX_DEPTH,
	localparam int BINS       = bins_per_contig(MAX_DEPTH),
	localparam int DEPTH      = NUM_CONTIGS * BINS,
	localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  tbl_entry_t    wdata,
	input  logic [AW-1:0] raddr,
	output tbl_entry_t    rdata,
	output logic          busy
);

	tbl_entry_t mem [DEPTH];

	logic [AW-1:0] clr_addr_q;
	logic          busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			busy_q     <= 1'b1;
		end else if (busy_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

	assign busy = busy_q;

endmodule

// File: hdl/binning_index_region_query.sv
// Top level of the binning index region query block.
//
// Input channel (in_valid/in_stall) carries load and query beats; output channel
// (out_valid/out_stall) returns exactly one result beat per input beat, in order.
// Config port: cfg_we writes the fine bin shift (index 0) or index_depth (index 1).
//
// A load writes the bin table on the accepting edge; out_valid rises once the
// finish state finds the output register free. A query runs a check state, then
// per level a setup state for the bin range shifts and walk states over the
// candidate bins (one bin table read per cycle through a single read port), then
// drain and finish. Errors caught in the check state skip the walk.
// One item is in flight at a time; in_stall is high until its result beat has
// been moved to the output register.
//
// After reset the presence table is swept clear, one entry per cycle over all
// NUM_CONTIGS * bins per contig entries (74898 with the defaults), with in_stall
// high; config writes are taken meanwhile. A stalled output beat holds, and the
// next result waits in the block until the output register frees up.
`include "assert_macros.svh"

module binning_index_region_query
	import biq_pkg::*;
#(
	parameter int NUM_CONTIGS = DEF_NUM_CONTIGS,
	parameter int MAX_DEPTH   = DEF_MAX_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [SHIFT_W-1:0] cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic               contig,
	input  logic [BIN_W-1:0]   bin_index,
	input  logic [VOFF_W-1:0]  virtual_offset,
	input  logic [POS_W-1:0]   region_begin,
	input  logic [POS_W-1:0]   region_end,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [COMP_W-1:0]  compressed_offset,
	output logic [BLK_W-1:0]   block_offset
);

	localparam int BINS  = bins_per_contig(MAX_DEPTH);
	localparam int DEPTH = NUM_CONTIGS * BINS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BW    = $clog2(BINS + 1);
	localparam int IW    = LEVEL_BITS * MAX_DEPTH + 1;

	state_t state_q, state_d;

	logic [SHIFT_W-1:0] fine_shift_q;
	logic [DEPTH_W-1:0] index_depth_q;

	logic             contig_q;
	logic [POS_W-1:0] begin_q, end_q, last_q;
	logic [SHIFT_W-1:0] s_q, sh_q;
	logic [LVL_W-1:0] lvl_q;
	logic [IW-1:0]    i_q, ihi_q;
	logic [BW-1:0]    t_q;
	status_t          err_q;
	logic             walk_q;

	logic             valid_s1;
	logic [POS_W-1:0] start_s1;

	logic              have_left_q, have_right_q;
	logic [POS_W-1:0]  left_start_q, right_start_q;
	logic [VOFF_W-1:0] left_v_q, right_v_q;

	logic              out_valid_q;
	status_t           status_q;
	logic [COMP_W-1:0] comp_q;
	logic [BLK_W-1:0]  blk_q;

	tbl_entry_t    tbl_wdata, tbl_rdata;
	logic          tbl_we, tbl_busy;
	logic [AW-1:0] load_addr, walk_addr, base_addr;

	logic              accept, load_ok, out_free;
	logic [5:0]        s_sum;
	logic [31:0]       lim;
	logic              cfg_bad, range_bad, chk_fail;
	status_t           chk_status;
	logic [SHIFT_W-1:0] sh_c;
	logic [IW-1:0]     lo_c, hi_c;
	logic [BW-1:0]     step_t;
	logic              last_lvl, lvl_done, advance;
	logic              left_side, upd_left, upd_right;
	logic              found;
	logic [VOFF_W-1:0] res_v;
	status_t           res_status;

	biq_table #(
		.NUM_CONTIGS (NUM_CONTIGS),
		.MAX_DEPTH   (MAX_DEPTH)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (tbl_we),
		.waddr  (load_addr),
		.wdata  (tbl_wdata),
		.raddr  (walk_addr),
		.rdata  (tbl_rdata),
		.busy   (tbl_busy)
	);

	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign load_ok   = (int'(contig) < NUM_CONTIGS) && (int'(bin_index) < BINS);
	assign load_addr = (contig ? AW'(BINS) : AW'(0)) + AW'(bin_index);
	assign tbl_wdata = '{present: 1'b1, voff: virtual_offset};
	assign base_addr = contig_q ? AW'(BINS) : AW'(0);
	assign walk_addr = base_addr + AW'(t_q) + AW'(i_q);

	// Query checks, evaluated in the check cycle.
	always_comb begin
		s_sum     = 6'(fine_shift_q) + 6'(LEVEL_BITS * index_depth_q);
		lim       = 32'd1 << s_sum[SHIFT_W-1:0];
		cfg_bad   = (int'(index_depth_q) > MAX_DEPTH) || (s_sum > 6'd31) ||
		            (int'(contig_q) >= NUM_CONTIGS);
		range_bad = ({1'b0, begin_q} >= lim) || ({1'b0, end_q} > lim);
		priority if (cfg_bad) begin
			chk_status = STAT_RANGE;
		end else if (end_q < begin_q) begin
			chk_status = STAT_ORDER;
		end else if (range_bad) begin
			chk_status = STAT_RANGE;
		end else begin
			chk_status = STAT_NO_BIN;
		end
		chk_fail = cfg_bad || (end_q < begin_q) || range_bad || (end_q == '0);
	end

	// Per-level bin range: shared shifter on the region bounds.
	always_comb begin
		sh_c     = s_q - SHIFT_W'(LEVEL_BITS * lvl_q);
		lo_c     = IW'(begin_q >> sh_c);
		hi_c     = IW'(last_q >> sh_c);
		step_t   = BW'(BW'(1) << (LEVEL_BITS * lvl_q));
		last_lvl = (lvl_q == LVL_W'(index_depth_q));
		lvl_done = ((state_q == ST_LEVEL) && (lo_c > hi_c)) ||
		           ((state_q == ST_WALK) && (i_q == ihi_q));
		advance  = lvl_done && !last_lvl;
	end

	// Compare stage: nearest start left of begin, else nearest at or right of it.
	always_comb begin
		left_side = start_s1 < begin_q;
		upd_left  = valid_s1 && tbl_rdata.present && left_side &&
		            (!have_left_q || (start_s1 > left_start_q));
		upd_right = valid_s1 && tbl_rdata.present && !left_side &&
		            (!have_right_q || (start_s1 < right_start_q));
	end

	always_comb begin
		found      = have_left_q || have_right_q;
		res_status = walk_q ? (found ? STAT_OK : STAT_NO_BIN) : err_q;
		res_v      = (walk_q && found) ? (have_left_q ? left_v_q : right_v_q) : '0;
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		tbl_we   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (!tbl_busy) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (op_t'(op) == OP_LOAD) begin
						tbl_we  = load_ok;
						state_d = ST_FINISH;
					end else begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				state_d = chk_fail ? ST_FINISH : ST_LEVEL;
			end
			ST_LEVEL: begin
				if (lo_c > hi_c) begin
					state_d = last_lvl ? ST_DRAIN : ST_LEVEL;
				end else begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (i_q == ihi_q) state_d = last_lvl ? ST_DRAIN : ST_LEVEL;
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			fine_shift_q  <= FINE_SHIFT_RST;
			index_depth_q <= INDEX_DEPTH_RST;
			lvl_q         <= '0;
			valid_s1      <= 1'b0;
			have_left_q   <= 1'b0;
			have_right_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= (state_q == ST_WALK);
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_FINE_SHIFT:  fine_shift_q  <= cfg_data;
					CFG_INDEX_DEPTH: index_depth_q <= cfg_data[DEPTH_W-1:0];
				endcase
			end
			if (accept) begin
				have_left_q  <= 1'b0;
				have_right_q <= 1'b0;
			end else begin
				if (upd_left) have_left_q <= 1'b1;
				if (upd_right) have_right_q <= 1'b1;
			end
			if (state_q == ST_CHECK) begin
				lvl_q <= '0;
			end else if (advance) begin
				lvl_q <= lvl_q + LVL_W'(1);
			end
			if ((state_q == ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			contig_q <= contig;
			begin_q  <= region_begin;
			end_q    <= region_end;
			err_q    <= load_ok ? STAT_OK : STAT_RANGE;
			walk_q   <= 1'b0;
		end
		if (state_q == ST_CHECK) begin
			s_q    <= s_sum[SHIFT_W-1:0];
			last_q <= end_q - POS_W'(1);
			t_q    <= '0;
			err_q  <= chk_status;
			walk_q <= !chk_fail;
		end
		if (state_q == ST_LEVEL) begin
			sh_q  <= sh_c;
			i_q   <= lo_c;
			ihi_q <= hi_c;
		end
		if (state_q == ST_WALK) begin
			i_q <= i_q + IW'(1);
		end
		if (advance) begin
			t_q <= t_q + step_t;
		end
		start_s1 <= POS_W'(32'(i_q) << sh_q);
		if (upd_left) begin
			left_start_q <= start_s1;
			left_v_q     <= tbl_rdata.voff;
		end
		if (upd_right) begin
			right_start_q <= start_s1;
			right_v_q     <= tbl_rdata.voff;
		end
		if ((state_q == ST_FINISH) && out_free) begin
			status_q <= res_status;
			comp_q   <= res_v[VOFF_W-1:BLK_W];
			blk_q    <= res_v[BLK_W-1:0];
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign compressed_offset = comp_q;
	assign block_offset      = blk_q;

	`ASSERT_AT(a_s1_from_walk, clk, arst_n, valid_s1 |-> $past(state_q == ST_WALK), "compare beat without a table read")
	`ASSERT_AT(a_walk_bounds, clk, arst_n, (state_q == ST_WALK) |-> (i_q <= ihi_q && lvl_q <= LVL_W'(index_depth_q)), "walk past the level range")
	`ASSERT_AT(a_fail_zero, clk, arst_n, (out_valid && status != STAT_OK) |-> (compressed_offset == '0 && block_offset == '0), "failed result carries an offset")
	`ASSERT_NEVER(a_no_load_in_clear, clk, arst_n, tbl_busy && tbl_we, "load during clearing pass")

endmodule
